@@ rtl/mfd_pkg.sv @@
`timescale 1ns / 1ps
package mfd_pkg;

  localparam int MaxVertices = 64;
  localparam int VtxW        = $clog2(MaxVertices);
  localparam int LvlW        = VtxW + 1;
  localparam int MaxEdges    = 1024;
  localparam int Slots       = 2 * MaxEdges;
  localparam int SlotW       = $clog2(Slots);
  localparam int LinkW       = SlotW + 1;
  localparam int CapBits     = 31;
  localparam int FlowW       = 47;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 7;

  localparam logic [LinkW-1:0] Nil        = LinkW'(Slots);
  localparam logic [LvlW-1:0]  Unreached  = LvlW'(MaxVertices);
  localparam logic [CapBits-1:0] PathLimit = {CapBits{1'b1}};
  localparam logic [FlowW-1:0] FlowMax    = {FlowW{1'b1}};

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SOURCE = 2'd0,
    CFG_SINK   = 2'd1,
    CFG_COUNT  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_SOLVE = 1'b1
  } op_e;

  typedef struct packed {
    logic [VtxW-1:0]     source;
    logic [VtxW-1:0]     sink;
    logic [CfgDataW-1:0] count;
  } cfg_t;

  typedef struct packed {
    logic [VtxW-1:0]    head;
    logic [CapBits-1:0] res;
    logic [LinkW-1:0]   link;
  } ent_t;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic [VtxW-1:0]  tail;
    logic [LinkW-1:0] link;
  } stk_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ADD_U,
    ST_ADD_U2,
    ST_ADD_V,
    ST_ADD_V2,
    ST_SOLVE,
    ST_BFS_INIT,
    ST_BFS_POP,
    ST_BFS_POPW,
    ST_BFS_FE,
    ST_BFS_EDGE,
    ST_BFS_ENT,
    ST_BFS_END,
    ST_AUG_START,
    ST_AUG_VTX,
    ST_AUG_CUR,
    ST_AUG_SCAN,
    ST_AUG_ENT,
    ST_AUG_LV,
    ST_AUG_POP,
    ST_MIN_RD,
    ST_MIN_STK,
    ST_MIN_ENT,
    ST_AP_RD,
    ST_AP_STK,
    ST_AP_FW,
    ST_AP_BW,
    ST_ACC,
    ST_EMIT
  } state_e;

endpackage

@@ rtl/mfd_core.sv @@
`timescale 1ns / 1ps
module mfd_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              opcode_i,
  input  logic [mfd_pkg::VtxW-1:0]          from_vertex_i,
  input  logic [mfd_pkg::VtxW-1:0]          to_vertex_i,
  input  logic [mfd_pkg::CapBits-1:0]       edge_capacity_i,
  input  mfd_pkg::cfg_t                     cfg_i,
  output logic                              done_o,
  output logic [mfd_pkg::FlowW-1:0]         max_flow_o,
  output logic                              store_overflow_o
);

  localparam int VtxW  = mfd_pkg::VtxW;
  localparam int LvlW  = mfd_pkg::LvlW;
  localparam int SlotW = mfd_pkg::SlotW;
  localparam int LinkW = mfd_pkg::LinkW;
  localparam int CapW  = mfd_pkg::CapBits;
  localparam int FlowW = mfd_pkg::FlowW;
  localparam int NV    = mfd_pkg::MaxVertices;

  mfd_pkg::state_e state_q, state_d;

  logic [VtxW-1:0]  u_q, u_d, v_q, v_d;
  logic [LvlW-1:0]  lu_q, lu_d;
  logic [LinkW-1:0] e_q, e_d, lnk_q, lnk_d;
  logic [CapW-1:0]  cap_q, cap_d, f_q, f_d;
  logic [LvlW-1:0]  depth_q, depth_d, idx_q, idx_d, rd_q, rd_d, wr_q, wr_d;
  logic [FlowW-1:0] total_q, total_d, flow_out_q, flow_out_d;
  logic [LinkW-1:0] used_q, used_d;
  logic             ovf_q, ovf_d, ovf_out_q, ovf_out_d, done_q, done_d;
  logic [NV-1:0]    fe_vld_q, fe_vld_d, lv_vld_q, lv_vld_d, cu_vld_q, cu_vld_d;

  mfd_pkg::ent_t    ent_mem [mfd_pkg::Slots];
  logic [LinkW-1:0] fe_mem  [NV];
  logic [LvlW-1:0]  lv_mem  [NV];
  logic [LinkW-1:0] cu_mem  [NV];
  logic [VtxW-1:0]  fifo_mem [NV];
  mfd_pkg::stk_t    stk_mem [NV];

  mfd_pkg::ent_t    ent_rd, ent_wd;
  logic [LinkW-1:0] fe_rd, fe_wd, cu_rd, cu_wd;
  logic [LvlW-1:0]  lv_rd, lv_wd;
  logic [VtxW-1:0]  fifo_rd, fifo_wd;
  mfd_pkg::stk_t    stk_rd, stk_wd;

  logic             ent_we, fe_we, lv_we, cu_we, fifo_we, stk_we;
  logic [SlotW-1:0] ent_wa, ent_ra;
  logic [VtxW-1:0]  fe_wa, fe_ra, lv_wa, lv_ra, cu_wa, cu_ra, fifo_wa, fifo_ra, stk_wa, stk_ra;

  logic [LvlW-1:0]  n_w, lu_inc, lv_eff_u, lv_eff_v, depth_m1;
  logic [LinkW-1:0] first_u, first_v, cur_u;
  logic             ent_live, solve_bad;
  logic [FlowW:0]   sum_w;
  logic [SlotW-1:0] e_slot, e_mate;

  assign n_w      = (cfg_i.count > LvlW'(NV)) ? LvlW'(NV) : cfg_i.count;
  assign lu_inc   = lu_q + LvlW'(1);
  assign depth_m1 = depth_q - LvlW'(1);
  assign first_u  = fe_vld_q[u_q] ? fe_rd : mfd_pkg::Nil;
  assign first_v  = fe_vld_q[v_q] ? fe_rd : mfd_pkg::Nil;
  assign cur_u    = cu_vld_q[u_q] ? cu_rd : first_u;
  assign lv_eff_u = lv_vld_q[u_q] ? lv_rd : mfd_pkg::Unreached;
  assign lv_eff_v = lv_vld_q[v_q] ? lv_rd : mfd_pkg::Unreached;
  assign ent_live = ({1'b0, ent_rd.head} < n_w) && (ent_rd.res != '0);
  assign solve_bad = ({1'b0, cfg_i.source} >= n_w) || ({1'b0, cfg_i.sink} >= n_w) ||
                     (cfg_i.source == cfg_i.sink);
  assign sum_w    = {1'b0, total_q} + (FlowW+1)'(f_q);
  assign e_slot   = e_q[SlotW-1:0];
  assign e_mate   = {e_q[SlotW-1:1], ~e_q[0]};

  always_comb begin
    state_d = state_q;
    case (state_q)
      mfd_pkg::ST_IDLE: begin
        if (start_i) begin
          if (opcode_i == mfd_pkg::OP_SOLVE) begin
            state_d = mfd_pkg::ST_SOLVE;
          end else if (used_q <= LinkW'(mfd_pkg::Slots - 2)) begin
            state_d = mfd_pkg::ST_ADD_U;
          end
        end
      end
      mfd_pkg::ST_ADD_U:  state_d = mfd_pkg::ST_ADD_U2;
      mfd_pkg::ST_ADD_U2: state_d = mfd_pkg::ST_ADD_V;
      mfd_pkg::ST_ADD_V:  state_d = mfd_pkg::ST_ADD_V2;
      mfd_pkg::ST_ADD_V2: state_d = mfd_pkg::ST_IDLE;
      mfd_pkg::ST_SOLVE:  state_d = solve_bad ? mfd_pkg::ST_EMIT : mfd_pkg::ST_BFS_INIT;
      mfd_pkg::ST_BFS_INIT: state_d = mfd_pkg::ST_BFS_POP;
      mfd_pkg::ST_BFS_POP: state_d = (rd_q == wr_q) ? mfd_pkg::ST_BFS_END :
                                                       mfd_pkg::ST_BFS_POPW;
      mfd_pkg::ST_BFS_POPW: state_d = mfd_pkg::ST_BFS_FE;
      mfd_pkg::ST_BFS_FE:   state_d = mfd_pkg::ST_BFS_EDGE;
      mfd_pkg::ST_BFS_EDGE: state_d = (e_q == mfd_pkg::Nil) ? mfd_pkg::ST_BFS_POP :
                                                               mfd_pkg::ST_BFS_ENT;
      mfd_pkg::ST_BFS_ENT:  state_d = mfd_pkg::ST_BFS_EDGE;
      mfd_pkg::ST_BFS_END:  state_d = lv_vld_q[cfg_i.sink] ? mfd_pkg::ST_AUG_START :
                                                              mfd_pkg::ST_EMIT;
      mfd_pkg::ST_AUG_START: state_d = mfd_pkg::ST_AUG_VTX;
      mfd_pkg::ST_AUG_VTX: state_d = (u_q == cfg_i.sink) ? mfd_pkg::ST_MIN_RD :
                                                            mfd_pkg::ST_AUG_CUR;
      mfd_pkg::ST_AUG_CUR: state_d = mfd_pkg::ST_AUG_SCAN;
      mfd_pkg::ST_AUG_SCAN: begin
        if (e_q != mfd_pkg::Nil) begin
          state_d = mfd_pkg::ST_AUG_ENT;
        end else if (depth_q == '0) begin
          state_d = mfd_pkg::ST_BFS_INIT;
        end else begin
          state_d = mfd_pkg::ST_AUG_POP;
        end
      end
      mfd_pkg::ST_AUG_ENT: state_d = ent_live ? mfd_pkg::ST_AUG_LV : mfd_pkg::ST_AUG_SCAN;
      mfd_pkg::ST_AUG_LV: begin
        if (lv_eff_v != lu_inc) begin
          state_d = mfd_pkg::ST_AUG_SCAN;
        end else if (depth_q[LvlW-1]) begin
          state_d = mfd_pkg::ST_BFS_INIT;
        end else begin
          state_d = mfd_pkg::ST_AUG_VTX;
        end
      end
      mfd_pkg::ST_AUG_POP: state_d = mfd_pkg::ST_AUG_VTX;
      mfd_pkg::ST_MIN_RD:  state_d = (idx_q == depth_q) ? mfd_pkg::ST_AP_RD :
                                                          mfd_pkg::ST_MIN_STK;
      mfd_pkg::ST_MIN_STK: state_d = mfd_pkg::ST_MIN_ENT;
      mfd_pkg::ST_MIN_ENT: state_d = mfd_pkg::ST_MIN_RD;
      mfd_pkg::ST_AP_RD:   state_d = (idx_q == depth_q) ? mfd_pkg::ST_ACC :
                                                          mfd_pkg::ST_AP_STK;
      mfd_pkg::ST_AP_STK:  state_d = mfd_pkg::ST_AP_FW;
      mfd_pkg::ST_AP_FW:   state_d = mfd_pkg::ST_AP_BW;
      mfd_pkg::ST_AP_BW:   state_d = mfd_pkg::ST_AP_RD;
      mfd_pkg::ST_ACC:     state_d = mfd_pkg::ST_AUG_START;
      mfd_pkg::ST_EMIT:    state_d = mfd_pkg::ST_IDLE;
      default:             state_d = mfd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ent_we = 1'b0; ent_wa = e_slot; ent_wd = ent_rd; ent_ra = e_slot;
    fe_we = 1'b0; fe_wa = u_q; fe_wd = used_q; fe_ra = u_q;
    lv_we = 1'b0; lv_wa = v_q; lv_wd = lu_inc; lv_ra = u_q;
    cu_we = 1'b0; cu_wa = u_q; cu_wd = e_q; cu_ra = u_q;
    fifo_we = 1'b0; fifo_wa = wr_q[VtxW-1:0]; fifo_wd = v_q; fifo_ra = rd_q[VtxW-1:0];
    stk_we = 1'b0; stk_wa = depth_q[VtxW-1:0]; stk_ra = idx_q[VtxW-1:0];
    stk_wd = '{slot: e_slot, tail: u_q, link: lnk_q};
    case (state_q)
      mfd_pkg::ST_ADD_U: fe_ra = u_q;
      mfd_pkg::ST_ADD_U2: begin
        ent_we = 1'b1;
        ent_wa = used_q[SlotW-1:0];
        ent_wd = '{head: v_q, res: cap_q, link: first_u};
        fe_we  = 1'b1;
        fe_wa  = u_q;
        fe_wd  = used_q;
      end
      mfd_pkg::ST_ADD_V: fe_ra = v_q;
      mfd_pkg::ST_ADD_V2: begin
        ent_we = 1'b1;
        ent_wa = used_q[SlotW-1:0] | SlotW'(1);
        ent_wd = '{head: u_q, res: '0, link: first_v};
        fe_we  = 1'b1;
        fe_wa  = v_q;
        fe_wd  = used_q | LinkW'(1);
      end
      mfd_pkg::ST_BFS_INIT: begin
        lv_we   = 1'b1;
        lv_wa   = cfg_i.source;
        lv_wd   = '0;
        fifo_we = 1'b1;
        fifo_wa = '0;
        fifo_wd = cfg_i.source;
      end
      mfd_pkg::ST_BFS_POPW: begin
        fe_ra = fifo_rd;
        lv_ra = fifo_rd;
      end
      mfd_pkg::ST_BFS_ENT: begin
        if (ent_live && !lv_vld_q[ent_rd.head]) begin
          lv_we   = 1'b1;
          lv_wa   = ent_rd.head;
          fifo_we = 1'b1;
          fifo_wd = ent_rd.head;
        end
      end
      mfd_pkg::ST_AUG_SCAN: begin
        if (e_q == mfd_pkg::Nil) begin
          cu_we  = 1'b1;
          stk_ra = depth_m1[VtxW-1:0];
        end
      end
      mfd_pkg::ST_AUG_ENT: lv_ra = ent_rd.head;
      mfd_pkg::ST_AUG_LV: begin
        if (lv_eff_v == lu_inc) begin
          cu_we  = 1'b1;
          stk_we = !depth_q[LvlW-1];
        end
      end
      mfd_pkg::ST_AUG_POP: begin
        cu_we = 1'b1;
        cu_wa = stk_rd.tail;
        cu_wd = stk_rd.link;
      end
      mfd_pkg::ST_MIN_STK: ent_ra = stk_rd.slot;
      mfd_pkg::ST_AP_STK:  ent_ra = stk_rd.slot;
      mfd_pkg::ST_AP_FW: begin
        ent_we = 1'b1;
        ent_wd = '{head: ent_rd.head, res: ent_rd.res - f_q, link: ent_rd.link};
        ent_ra = e_mate;
      end
      mfd_pkg::ST_AP_BW: begin
        ent_we = 1'b1;
        ent_wa = e_mate;
        ent_wd = '{head: ent_rd.head, res: ent_rd.res + f_q, link: ent_rd.link};
      end
      default: ;
    endcase
  end

  always_comb begin
    u_d = u_q; v_d = v_q; lu_d = lu_q; e_d = e_q; lnk_d = lnk_q; cap_d = cap_q;
    f_d = f_q; depth_d = depth_q; idx_d = idx_q; rd_d = rd_q; wr_d = wr_q;
    total_d = total_q; used_d = used_q; ovf_d = ovf_q;
    flow_out_d = flow_out_q; ovf_out_d = ovf_out_q; done_d = 1'b0;
    fe_vld_d = fe_vld_q; lv_vld_d = lv_vld_q; cu_vld_d = cu_vld_q;
    if (fe_we) fe_vld_d[fe_wa] = 1'b1;
    if (cu_we) cu_vld_d[cu_wa] = 1'b1;
    if (lv_we) lv_vld_d[lv_wa] = 1'b1;
    case (state_q)
      mfd_pkg::ST_IDLE: begin
        if (start_i) begin
          u_d     = from_vertex_i;
          v_d     = to_vertex_i;
          cap_d   = edge_capacity_i;
          total_d = '0;
          if (opcode_i == mfd_pkg::OP_ADD && used_q > LinkW'(mfd_pkg::Slots - 2)) begin
            ovf_d = 1'b1;
          end
        end
      end
      mfd_pkg::ST_ADD_V2: used_d = used_q + LinkW'(2);
      mfd_pkg::ST_BFS_INIT: begin
        lv_vld_d = '0;
        lv_vld_d[cfg_i.source] = 1'b1;
        rd_d = '0;
        wr_d = LvlW'(1);
      end
      mfd_pkg::ST_BFS_POP:  if (rd_q != wr_q) rd_d = rd_q + LvlW'(1);
      mfd_pkg::ST_BFS_POPW: u_d = fifo_rd;
      mfd_pkg::ST_BFS_FE: begin
        e_d  = first_u;
        lu_d = lv_rd;
      end
      mfd_pkg::ST_BFS_ENT: begin
        e_d = ent_rd.link;
        if (fifo_we) wr_d = wr_q + LvlW'(1);
      end
      mfd_pkg::ST_BFS_END: cu_vld_d = '0;
      mfd_pkg::ST_AUG_START: begin
        depth_d = '0;
        u_d     = cfg_i.source;
      end
      mfd_pkg::ST_AUG_VTX: begin
        idx_d = '0;
        f_d   = mfd_pkg::PathLimit;
      end
      mfd_pkg::ST_AUG_CUR: begin
        e_d  = cur_u;
        lu_d = lv_eff_u;
      end
      mfd_pkg::ST_AUG_SCAN: begin
        if (e_q == mfd_pkg::Nil && depth_q != '0) depth_d = depth_m1;
      end
      mfd_pkg::ST_AUG_ENT: begin
        v_d   = ent_rd.head;
        lnk_d = ent_rd.link;
        if (!ent_live) e_d = ent_rd.link;
      end
      mfd_pkg::ST_AUG_LV: begin
        if (lv_eff_v != lu_inc) begin
          e_d = lnk_q;
        end else if (!depth_q[LvlW-1]) begin
          depth_d = depth_q + LvlW'(1);
          u_d     = v_q;
        end
      end
      mfd_pkg::ST_AUG_POP: u_d = stk_rd.tail;
      mfd_pkg::ST_MIN_RD: begin
        if (idx_q == depth_q) idx_d = '0;
        else idx_d = idx_q + LvlW'(1);
      end
      mfd_pkg::ST_MIN_ENT: if (ent_rd.res < f_q) f_d = ent_rd.res;
      mfd_pkg::ST_AP_RD:   if (idx_q != depth_q) idx_d = idx_q + LvlW'(1);
      mfd_pkg::ST_AP_STK:  e_d = {1'b0, stk_rd.slot};
      mfd_pkg::ST_ACC:     total_d = sum_w[FlowW] ? mfd_pkg::FlowMax : sum_w[FlowW-1:0];
      mfd_pkg::ST_EMIT: begin
        done_d     = 1'b1;
        flow_out_d = total_q;
        ovf_out_d  = ovf_q;
        ovf_d      = 1'b0;
        used_d     = '0;
        fe_vld_d   = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mfd_pkg::ST_IDLE;
      u_q        <= '0;
      v_q        <= '0;
      lu_q       <= '0;
      e_q        <= '0;
      lnk_q      <= '0;
      cap_q      <= '0;
      f_q        <= '0;
      depth_q    <= '0;
      idx_q      <= '0;
      rd_q       <= '0;
      wr_q       <= '0;
      total_q    <= '0;
      used_q     <= '0;
      ovf_q      <= 1'b0;
      flow_out_q <= '0;
      ovf_out_q  <= 1'b0;
      done_q     <= 1'b0;
      fe_vld_q   <= '0;
      lv_vld_q   <= '0;
      cu_vld_q   <= '0;
    end else begin
      state_q    <= state_d;
      u_q        <= u_d;
      v_q        <= v_d;
      lu_q       <= lu_d;
      e_q        <= e_d;
      lnk_q      <= lnk_d;
      cap_q      <= cap_d;
      f_q        <= f_d;
      depth_q    <= depth_d;
      idx_q      <= idx_d;
      rd_q       <= rd_d;
      wr_q       <= wr_d;
      total_q    <= total_d;
      used_q     <= used_d;
      ovf_q      <= ovf_d;
      flow_out_q <= flow_out_d;
      ovf_out_q  <= ovf_out_d;
      done_q     <= done_d;
      fe_vld_q   <= fe_vld_d;
      lv_vld_q   <= lv_vld_d;
      cu_vld_q   <= cu_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    ent_rd <= ent_mem[ent_ra];
  end

  always_ff @(posedge clk_i) begin
    if (fe_we) fe_mem[fe_wa] <= fe_wd;
    fe_rd <= fe_mem[fe_ra];
  end

  always_ff @(posedge clk_i) begin
    if (lv_we) lv_mem[lv_wa] <= lv_wd;
    lv_rd <= lv_mem[lv_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cu_we) cu_mem[cu_wa] <= cu_wd;
    cu_rd <= cu_mem[cu_ra];
  end

  always_ff @(posedge clk_i) begin
    if (fifo_we) fifo_mem[fifo_wa] <= fifo_wd;
    fifo_rd <= fifo_mem[fifo_ra];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd <= stk_mem[stk_ra];
  end

  assign busy_o           = (state_q != mfd_pkg::ST_IDLE);
  assign done_o           = done_q;
  assign max_flow_o       = flow_out_q;
  assign store_overflow_o = ovf_out_q;

endmodule

@@ rtl/max_flow_dinic.sv @@
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// command   start_i / busy_o          opcode_i, from_vertex_i, to_vertex_i, edge_capacity_i
// result    done_o (one-cycle strobe) max_flow_o, store_overflow_o
// config    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
// An edge beat holds busy_o while writing its pair; a beat on a full store leaves it low.
// A solve runs one memory access per cycle over the edge store, so its length grows with
// the number of edges scanned per level pass and per augmenting path, plus path length.
// Reset clears all vertex lists at once through valid bits; no clearing pass is needed.
// The result strobe cannot be stalled by the receiver.
module max_flow_dinic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                opcode_i,
  input  logic [mfd_pkg::VtxW-1:0]            from_vertex_i,
  input  logic [mfd_pkg::VtxW-1:0]            to_vertex_i,
  input  logic [mfd_pkg::CapBits-1:0]         edge_capacity_i,
  output logic                                done_o,
  output logic [mfd_pkg::FlowW-1:0]           max_flow_o,
  output logic                                store_overflow_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mfd_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [mfd_pkg::CfgDataW-1:0]        cfg_data_i
);

  mfd_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        mfd_pkg::CFG_SOURCE: cfg_d.source = cfg_data_i[mfd_pkg::VtxW-1:0];
        mfd_pkg::CFG_SINK:   cfg_d.sink   = cfg_data_i[mfd_pkg::VtxW-1:0];
        mfd_pkg::CFG_COUNT:  cfg_d.count  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source <= '0;
      cfg_q.sink   <= mfd_pkg::VtxW'(mfd_pkg::MaxVertices - 1);
      cfg_q.count  <= mfd_pkg::CfgDataW'(mfd_pkg::MaxVertices);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mfd_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .opcode_i         (opcode_i),
    .from_vertex_i    (from_vertex_i),
    .to_vertex_i      (to_vertex_i),
    .edge_capacity_i  (edge_capacity_i),
    .cfg_i            (cfg_q),
    .done_o           (done_o),
    .max_flow_o       (max_flow_o),
    .store_overflow_o (store_overflow_o)
  );

endmodule

@@ rtl/mfd_checker.sv @@
`timescale 1ns / 1ps
module mfd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic opcode_i,
  input logic done_o,
  input logic cfg_ready_o
);

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result strobe while busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_solve_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && opcode_i) |=> busy_o) else $error("solve did not start");

  a_add_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !opcode_i) |=> !done_o) else $error("edge beat made a result");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o) else $error("configuration port not ready");

endmodule

bind max_flow_dinic mfd_checker u_mfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .opcode_i    (opcode_i),
  .done_o      (done_o),
  .cfg_ready_o (cfg_ready_o)
);

@@ sim/max_flow_dinic_tb.sv @@
`timescale 1ns / 1ps
module max_flow_dinic_tb;

  localparam int  NumSlots  = 2 * 1024;
  localparam int  NoEdge    = NumSlots;
  localparam int  NumVtx    = 64;
  localparam int  CycleLimit = 4000000;

  typedef struct {
    logic [mfd_pkg::FlowW-1:0] flow;
    logic                      ovf;
  } flow_result_t;

  typedef struct {
    mfd_pkg::op_e     op;
    int unsigned      from_v;
    int unsigned      to_v;
    int unsigned      cap;
    bit               typed;
    longint unsigned  flow;
    bit               ovf;
  } dir_row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start_i;
  logic                          busy_o;
  logic                          opcode_i;
  logic [mfd_pkg::VtxW-1:0]      from_vertex_i;
  logic [mfd_pkg::VtxW-1:0]      to_vertex_i;
  logic [mfd_pkg::CapBits-1:0]   edge_capacity_i;
  logic                          done_o;
  logic [mfd_pkg::FlowW-1:0]     max_flow_o;
  logic                          store_overflow_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [mfd_pkg::CfgIdxW-1:0]   cfg_index_i;
  logic [mfd_pkg::CfgDataW-1:0]  cfg_data_i;

  max_flow_dinic u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .opcode_i        (opcode_i),
    .from_vertex_i   (from_vertex_i),
    .to_vertex_i     (to_vertex_i),
    .edge_capacity_i (edge_capacity_i),
    .done_o          (done_o),
    .max_flow_o      (max_flow_o),
    .store_overflow_o(store_overflow_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Shadow of the block's configuration and graph.
  int unsigned src_r, snk_r, cnt_r;
  int unsigned e_head [NumSlots];
  int unsigned e_link [NumSlots];
  int unsigned e_part [NumSlots];
  longint      e_cap  [NumSlots];
  longint      e_flow [NumSlots];
  int unsigned first_e [NumVtx];
  int unsigned lvl [NumVtx];
  int unsigned cur [NumVtx];
  int unsigned fifo [NumVtx];
  int unsigned path [NumVtx];
  int unsigned slots_used;
  bit          dropped;

  flow_result_t flow_q[$];
  int          mismatches;
  int          solves_seen;
  int          edges_sent;
  longint      cycles;
  bit          dir_typed;
  longint unsigned dir_flow;
  bit          dir_ovf;
  bit          gaps_on;

  function automatic void graph_clear();
    int unsigned i;
    for (i = 0; i < NumVtx; i++) begin
      first_e[i] = NoEdge;
      lvl[i]     = NumVtx;
      cur[i]     = 0;
    end
    slots_used = 0;
    dropped    = 1'b0;
  endfunction

  function automatic void link_slot(int unsigned s, int unsigned tail, int unsigned head,
                                    longint cap, int unsigned partner);
    e_head[s]     = head;
    e_cap[s]      = cap;
    e_flow[s]     = 0;
    e_part[s]     = partner;
    e_link[s]     = first_e[tail];
    first_e[tail] = s;
  endfunction

  function automatic void graph_add_edge(int unsigned u, int unsigned v, longint cap);
    int unsigned f;
    if (slots_used + 2 > NumSlots) begin
      dropped = 1'b1;
      return;
    end
    f = slots_used;
    link_slot(f, u, v, cap, f + 1);
    link_slot(f + 1, v, u, 0, f);
    slots_used += 2;
  endfunction

  function automatic bit level_pass(int unsigned n);
    int unsigned i, rd, wr, e, u, v;
    rd = 0;
    wr = 0;
    for (i = 0; i < n; i++) lvl[i] = NumVtx;
    lvl[src_r] = 0;
    fifo[wr++] = src_r;
    while (rd < wr) begin
      u = fifo[rd++];
      for (e = first_e[u]; e != NoEdge; e = e_link[e]) begin
        v = e_head[e];
        if (v < n && e_cap[e] - e_flow[e] > 0 && lvl[v] == NumVtx && wr < NumVtx) begin
          lvl[v] = lvl[u] + 1;
          fifo[wr++] = v;
        end
      end
    end
    return lvl[snk_r] != NumVtx;
  endfunction

  function automatic longint push_path(int unsigned n);
    int unsigned depth, u, e, i, v;
    longint f, r;
    depth = 0;
    u = src_r;
    while (1) begin
      if (u == snk_r) begin
        f = 64'h7FFF_FFFF;
        for (i = 0; i < depth; i++) begin
          r = e_cap[path[i]] - e_flow[path[i]];
          if (r < f) f = r;
        end
        for (i = 0; i < depth; i++) begin
          e = path[i];
          e_flow[e] += f;
          e_flow[e_part[e]] -= f;
        end
        return f;
      end
      e = cur[u];
      while (e != NoEdge) begin
        v = e_head[e];
        if (v < n && e_cap[e] - e_flow[e] > 0 && lvl[v] == lvl[u] + 1) break;
        e = e_link[e];
      end
      cur[u] = e;
      if (e != NoEdge) begin
        if (depth >= NumVtx) return 0;
        path[depth++] = e;
        u = e_head[e];
      end else begin
        if (depth == 0) return 0;
        depth--;
        e = path[depth];
        u = e_head[e_part[e]];
        cur[u] = e_link[e];
      end
    end
    return 0;
  endfunction

  function automatic longint unsigned compute_max_flow();
    int unsigned n, i;
    longint unsigned total;
    longint f;
    n = (cnt_r > NumVtx) ? NumVtx : cnt_r;
    total = 0;
    if (src_r >= n || snk_r >= n || src_r == snk_r) return 0;
    while (level_pass(n)) begin
      for (i = 0; i < n; i++) cur[i] = first_e[i];
      while (1) begin
        f = push_path(n);
        if (f <= 0) break;
        total += f;
        if (total > mfd_pkg::FlowMax) total = mfd_pkg::FlowMax;
      end
    end
    return total;
  endfunction

  always @(posedge clk_i) begin
    flow_result_t want, res;
    if (rst_ni) begin
      cycles++;
      if (done_o) begin
        solves_seen++;
        if (flow_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat: flow %0d", max_flow_o);
        end else begin
          want = flow_q.pop_front();
          if (want.flow !== max_flow_o || want.ovf !== store_overflow_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: flow exp %0d got %0d, overflow exp %0b got %0b",
                       want.flow, max_flow_o, want.ovf, store_overflow_o);
          end
        end
      end
      if (start_i && !busy_o) begin
        if (opcode_i == mfd_pkg::OP_ADD) begin
          graph_add_edge(from_vertex_i, to_vertex_i, edge_capacity_i);
        end else begin
          res.flow = mfd_pkg::FlowW'(compute_max_flow());
          res.ovf  = dropped;
          if (dir_typed) begin
            res.flow = mfd_pkg::FlowW'(dir_flow);
            res.ovf  = dir_ovf;
          end
          flow_q.insert(flow_q.size(), res);
          graph_clear();
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (mfd_pkg::cfg_idx_e'(cfg_index_i))
          mfd_pkg::CFG_SOURCE: src_r = cfg_data_i[mfd_pkg::VtxW-1:0];
          mfd_pkg::CFG_SINK:   snk_r = cfg_data_i[mfd_pkg::VtxW-1:0];
          mfd_pkg::CFG_COUNT:  cnt_r = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_item(mfd_pkg::op_e op, int unsigned fv, int unsigned tv,
                           int unsigned cap);
    opcode_i        = op;
    from_vertex_i   = mfd_pkg::VtxW'(fv);
    to_vertex_i     = mfd_pkg::VtxW'(tv);
    edge_capacity_i = mfd_pkg::CapBits'(cap);
    start_i         = 1'b1;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    if (op == mfd_pkg::OP_ADD) edges_sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start_i = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
  endtask

  task automatic cfg_write(mfd_pkg::cfg_idx_e idx, int unsigned val);
    cfg_index_i = idx;
    cfg_data_i  = mfd_pkg::CfgDataW'(val);
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain();
    start_i = 1'b0;
    while (flow_q.size() != 0 || busy_o) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_config(int unsigned s, int unsigned k, int unsigned c);
    drain();
    cfg_write(mfd_pkg::CFG_SOURCE, s);
    cfg_write(mfd_pkg::CFG_SINK, k);
    cfg_write(mfd_pkg::CFG_COUNT, c);
  endtask

  function automatic int unsigned rand_cap();
    case ($urandom_range(0, 3))
      0:       return $urandom & 32'h7FFF_FFFF;
      1:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: return $urandom_range(0, 20);
    endcase
  endfunction

  dir_row_t dir_rows [22] = '{
    '{mfd_pkg::OP_SOLVE, 0,  0,  0,            1, 0,              0},
    '{mfd_pkg::OP_ADD,   0,  63, 32'h7FFFFFFF, 0, 0,              0},
    '{mfd_pkg::OP_SOLVE, 0,  0,  0,            1, 64'd2147483647, 0},
    '{mfd_pkg::OP_ADD,   0,  63, 32'h7FFFFFFF, 0, 0,              0},
    '{mfd_pkg::OP_ADD,   0,  63, 32'h7FFFFFFF, 0, 0,              0},
    '{mfd_pkg::OP_SOLVE, 0,  0,  0,            1, 64'd4294967294, 0},
    '{mfd_pkg::OP_ADD,   0,  1,  5,            0, 0,              0},
    '{mfd_pkg::OP_ADD,   1,  63, 3,            0, 0,              0},
    '{mfd_pkg::OP_ADD,   1,  1,  9,            0, 0,              0},
    '{mfd_pkg::OP_ADD,   63, 0,  7,            0, 0,              0},
    '{mfd_pkg::OP_SOLVE, 0,  0,  0,            1, 3,              0},
    '{mfd_pkg::OP_ADD,   0,  63, 0,            0, 0,              0},
    '{mfd_pkg::OP_SOLVE, 0,  0,  0,            1, 0,              0},
    '{mfd_pkg::OP_ADD,   0,  10, 6,            0, 0,              0},
    '{mfd_pkg::OP_ADD,   10, 20, 4,            0, 0,              0},
    '{mfd_pkg::OP_ADD,   0,  20, 3,            0, 0,              0},
    '{mfd_pkg::OP_ADD,   20, 63, 8,            0, 0,              0},
    '{mfd_pkg::OP_ADD,   10, 63, 1,            0, 0,              0},
    '{mfd_pkg::OP_ADD,   20, 10, 2,            0, 0,              0},
    '{mfd_pkg::OP_SOLVE, 0,  0,  0,            0, 0,              0},
    '{mfd_pkg::OP_ADD,   42, 21, 32'h2AAAAAAA, 0, 0,              0},
    '{mfd_pkg::OP_SOLVE, 0,  0,  0,            1, 0,              0}
  };

  initial begin
    int unsigned pool [6];
    int unsigned nv, g, e, i, s, k, c;
    rst_ni = 1'b0;
    start_i = 1'b0;
    opcode_i = mfd_pkg::OP_ADD;
    from_vertex_i = '0;
    to_vertex_i = '0;
    edge_capacity_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = mfd_pkg::CFG_SOURCE;
    cfg_data_i = '0;
    mismatches = 0;
    solves_seen = 0;
    edges_sent = 0;
    cycles = 0;
    dir_typed = 1'b0;
    gaps_on = 1'b1;
    src_r = 0;
    snk_r = 63;
    cnt_r = 64;
    graph_clear();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[r]) begin
      dir_typed = dir_rows[r].typed;
      dir_flow  = dir_rows[r].flow;
      dir_ovf   = dir_rows[r].ovf;
      send_item(dir_rows[r].op, dir_rows[r].from_v, dir_rows[r].to_v, dir_rows[r].cap);
    end
    drain();
    dir_typed = 1'b0;

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin s = 0;  k = 63; c = 64;  end
        1: begin s = 63; k = 0;  c = 64;  end
        2: begin s = 5;  k = 5;  c = 64;  end
        3: begin s = 0;  k = 3;  c = 127; end
        4: begin s = 0;  k = 63; c = 0;   end
        5: begin s = 2;  k = 40; c = 20;  end
        6: begin s = 0;  k = 1;  c = 2;   end
        default: begin
          c = $urandom_range(2, 64);
          s = $urandom_range(0, c - 1);
          k = $urandom_range(0, c - 1);
        end
      endcase
      if (p == 9) gaps_on = 1'b0;
      set_config(s, k, c);
      nv = (c > NumVtx) ? NumVtx : ((c < 2) ? 2 : c);
      if (p == 7) begin
        // Fill the edge store past its end so that the overflow flag is raised.
        for (e = 0; e < 1025; e++)
          send_item(mfd_pkg::OP_ADD, $urandom_range(0, nv - 1), $urandom_range(0, nv - 1),
                    rand_cap());
        send_item(mfd_pkg::OP_SOLVE, 0, 0, 0);
      end
      for (g = 0; g < 2; g++) begin
        pool[0] = s;
        pool[1] = k;
        for (i = 2; i < 6; i++) pool[i] = $urandom_range(0, nv - 1);
        for (e = $urandom_range(1, 6); e > 0; e--) begin
          if ($urandom_range(0, 4) == 0)
            send_item(mfd_pkg::OP_ADD, $urandom_range(0, 63), $urandom_range(0, 63),
                      rand_cap());
          else
            send_item(mfd_pkg::OP_ADD, pool[$urandom_range(0, 5)],
                      pool[$urandom_range(0, 5)], rand_cap());
        end
        send_item(mfd_pkg::OP_SOLVE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
      end
    end
    drain();
    repeat (50) @(negedge clk_i);

    $display("Covered %0d edge beats and %0d solve results over ten register settings,",
             edges_sent, solves_seen);
    $display("including a full edge store, an empty graph and source equal to sink.");
    if (mismatches == 0 && flow_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
